/* rtl/voxel_packet_framer_unit_macros.svh */
// Assertion macros shared by the framer RTL.
// Depends on: clk and rst_n being visible where the macros are used.
`ifndef VOXEL_PACKET_FRAMER_UNIT_MACROS_SVH
`define VOXEL_PACKET_FRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define VPF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vpf_pkg.sv */
// Shared types and constants of the voxel packet framer.
// No dependencies.
package vpf_pkg;

    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 8;
    localparam int VPP_W       = 13;
    localparam int TS_W        = 64;
    localparam int TOTAL_W     = 32;
    localparam int PKT_W       = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [VPP_W-1:0] MAX_VPP = VPP_W'(6000);
    localparam logic [VPP_W-1:0] MIN_VPP = VPP_W'(1);

    localparam int BYTE_IDX_W = 5;
    localparam logic [BYTE_IDX_W-1:0] FIRST_VOXEL_BYTE = BYTE_IDX_W'(16);
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE        = BYTE_IDX_W'(25);
    localparam logic [BYTE_IDX_W-1:0] FIRST_BYTE       = BYTE_IDX_W'(0);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMESTAMP   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_VOXEL_TOTAL = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_VPP         = CFG_INDEX_W'(2);

    typedef struct packed {
        logic [TS_W-1:0]    timestamp;
        logic [TOTAL_W-1:0] voxel_total;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               header;
        logic [PKT_W-1:0]   pkt_index;
        logic               closes;
    } cmd_t;

endpackage

/* rtl/vpf_front.sv */
// Front end: config registers, packet counters, voxel classification.
// Depends on: vpf_pkg, voxel_packet_framer_unit_macros.svh.
`include "voxel_packet_framer_unit_macros.svh"

module vpf_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [vpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    input  logic                            full,
    input  logic [vpf_pkg::COORD_W-1:0]     coord_x,
    input  logic [vpf_pkg::COORD_W-1:0]     coord_y,
    input  logic [vpf_pkg::COORD_W-1:0]     coord_z,
    input  logic [vpf_pkg::COLOR_W-1:0]     red,
    input  logic [vpf_pkg::COLOR_W-1:0]     green,
    input  logic [vpf_pkg::COLOR_W-1:0]     blue,
    input  logic                            frame_end,
    output logic                            cmd_write,
    output vpf_pkg::cmd_t                   cmd,
    output vpf_pkg::cfg_t                   cfg
);
    import vpf_pkg::*;

    logic [TS_W-1:0]    ts_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [VPP_W-1:0]   vpp_reg;
    logic [VPP_W-1:0]   vip_reg;
    logic [VPP_W-1:0]   vip_next;
    logic [PKT_W-1:0]   pkt_reg;
    logic [PKT_W-1:0]   pkt_next;
    logic [VPP_W-1:0]   limit;
    logic [VPP_W-1:0]   vip_inc;
    logic               accept;
    logic               closes;

    assign accept  = push && !full;
    assign vip_inc = vip_reg + MIN_VPP;

    always_comb
    begin
        if (vpp_reg == '0)
        begin
            limit = MIN_VPP;
        end
        else if (vpp_reg > MAX_VPP)
        begin
            limit = MAX_VPP;
        end
        else
        begin
            limit = vpp_reg;
        end
    end

    assign closes = frame_end || (vip_inc >= limit);

    always_comb
    begin
        vip_next = vip_reg;
        pkt_next = pkt_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                vip_next = '0;
                pkt_next = '0;
            end
            else if (closes)
            begin
                vip_next = '0;
                pkt_next = pkt_reg + PKT_W'(1);
            end
            else
            begin
                vip_next = vip_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg    <= '0;
            total_reg <= '0;
            vpp_reg   <= MAX_VPP;
            vip_reg   <= '0;
            pkt_reg   <= '0;
        end
        else
        begin
            vip_reg <= vip_next;
            pkt_reg <= pkt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TIMESTAMP:   ts_reg    <= cfg_data;
                    CFG_VOXEL_TOTAL: total_reg <= cfg_data[TOTAL_W-1:0];
                    CFG_VPP:         vpp_reg   <= cfg_data[VPP_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    assign cmd_write     = accept;
    assign cmd.x         = coord_x;
    assign cmd.y         = coord_y;
    assign cmd.z         = coord_z;
    assign cmd.r         = red;
    assign cmd.g         = green;
    assign cmd.b         = blue;
    assign cmd.header    = (vip_reg == '0);
    assign cmd.pkt_index = pkt_reg;
    assign cmd.closes    = closes;

    assign cfg.timestamp   = ts_reg;
    assign cfg.voxel_total = total_reg;

    `VPF_ASSERT_NEXT(a_close_clears_count, accept && closes, vip_reg == '0, "count not cleared on close")
    `VPF_ASSERT_NEXT(a_frame_end_restarts, accept && frame_end, pkt_reg == '0 && vip_reg == '0, "frame end did not restart")

endmodule

/* rtl/vpf_cmd_fifo.sv */
// Short request queue between the front end and the serializer.
// Depends on: vpf_pkg.
module vpf_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  vpf_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output vpf_pkg::cmd_t rd_data,
    output logic          rd_valid
);
    import vpf_pkg::*;

    cmd_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + FIFO_CNT_W'(1);
                2'b01:   count_reg <= count_reg - FIFO_CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

/* rtl/vpf_back.sv */
// Back end: turns queued voxel requests into a byte stream, one byte per cycle while the receiver keeps popping.
// Depends on: vpf_pkg, voxel_packet_framer_unit_macros.svh.
`include "voxel_packet_framer_unit_macros.svh"

module vpf_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  vpf_pkg::cfg_t               cfg,
    input  vpf_pkg::cmd_t               head,
    input  logic                        head_valid,
    output logic                        head_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [vpf_pkg::COLOR_W-1:0] data_byte,
    output logic                        packet_end,
    output logic                        run_last
);
    import vpf_pkg::*;

    localparam int FRAME_BITS = TS_W + PKT_W + TOTAL_W + 3 * COORD_W + 4 * COLOR_W;

    logic                  busy_reg;
    logic [BYTE_IDX_W-1:0] idx_reg;
    logic                  out_valid_reg;
    logic [COLOR_W-1:0]    data_reg;
    logic                  pend_reg;
    logic                  last_reg;
    logic [BYTE_IDX_W-1:0] cur_idx;
    logic                  advance;
    logic                  at_last;
    logic [FRAME_BITS-1:0] frame_bits;

    always_comb
    begin
        if (busy_reg)
        begin
            cur_idx = idx_reg;
        end
        else if (head.header)
        begin
            cur_idx = FIRST_BYTE;
        end
        else
        begin
            cur_idx = FIRST_VOXEL_BYTE;
        end
    end

    assign advance  = head_valid && (!out_valid_reg || pop);
    assign at_last  = (cur_idx == LAST_BYTE);
    assign head_pop = advance && at_last;

    // byte 0 at the bottom, little-endian throughout
    assign frame_bits = {COLOR_W'(0), head.b, head.g, head.r,
                         head.z, head.y, head.x,
                         cfg.voxel_total, head.pkt_index, cfg.timestamp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= FIRST_BYTE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                busy_reg      <= !at_last;
                idx_reg       <= cur_idx + BYTE_IDX_W'(1);
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= frame_bits[{cur_idx, 3'b000} +: COLOR_W];
            pend_reg <= at_last && head.closes;
            last_reg <= at_last;
        end
    end

    assign empty      = !out_valid_reg;
    assign data_byte  = data_reg;
    assign packet_end = pend_reg;
    assign run_last   = last_reg;

    `VPF_ASSERT_IMPL(a_busy_has_head, busy_reg, head_valid, "serializer lost its request")
    `VPF_ASSERT_IMPL(a_busy_idx_range, busy_reg, idx_reg != FIRST_BYTE && idx_reg <= LAST_BYTE, "byte index out of range")

endmodule

/* rtl/voxel_packet_framer_unit.sv */
// Voxel packet framer: serializes voxels into a byte stream of packets, each packet
// opening with a 16-byte header. Each accepted voxel yields 10 bytes, or 26 when it
// opens a packet; bytes leave one per cycle while the receiver keeps popping, through
// the single byte output register of the serializer. A four-entry request queue lets
// voxels be accepted while earlier ones are still being sent. Config writes are
// expected only while no bytes are outstanding.
// Depends on: vpf_pkg, vpf_front, vpf_cmd_fifo, vpf_back.
module voxel_packet_framer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [vpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [vpf_pkg::COORD_W-1:0]     coord_x,
    input  logic [vpf_pkg::COORD_W-1:0]     coord_y,
    input  logic [vpf_pkg::COORD_W-1:0]     coord_z,
    input  logic [vpf_pkg::COLOR_W-1:0]     red,
    input  logic [vpf_pkg::COLOR_W-1:0]     green,
    input  logic [vpf_pkg::COLOR_W-1:0]     blue,
    input  logic                            frame_end,
    output logic                            empty,
    input  logic                            pop,
    output logic [vpf_pkg::COLOR_W-1:0]     data_byte,
    output logic                            packet_end,
    output logic                            run_last
);
    import vpf_pkg::*;

    logic cmd_write;
    cmd_t cmd;
    cfg_t cfg;
    cmd_t head;
    logic head_valid;
    logic head_pop;

    vpf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .frame_end (frame_end),
        .cmd_write (cmd_write),
        .cmd       (cmd),
        .cfg       (cfg)
    );

    vpf_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_write),
        .wr_data  (cmd),
        .full     (full),
        .rd_en    (head_pop),
        .rd_data  (head),
        .rd_valid (head_valid)
    );

    vpf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .data_byte  (data_byte),
        .packet_end (packet_end),
        .run_last   (run_last)
    );

endmodule

/* test/voxel_packet_framer_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for voxel_packet_framer_unit: predicts the byte stream of every voxel request
// and checks each popped byte, with random idling on both sides and a long output stall.
// Depends on: vpf_pkg, voxel_packet_framer_unit.
module voxel_packet_framer_unit_tb;
    import vpf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = CFG_INDEX_W'(3);
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int CHOKE_CYCLES  = 300;
    localparam int RANDOM_VOXELS = 175;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               last;
    } voxel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] data;
        logic               pkt_end;
        logic               last;
    } stream_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [COORD_W-1:0]     coord_x = '0;
    logic [COORD_W-1:0]     coord_y = '0;
    logic [COORD_W-1:0]     coord_z = '0;
    logic [COLOR_W-1:0]     red = '0;
    logic [COLOR_W-1:0]     green = '0;
    logic [COLOR_W-1:0]     blue = '0;
    logic                   frame_end = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [COLOR_W-1:0]     data_byte;
    logic                   packet_end;
    logic                   run_last;

    // framer state and registers as the block should hold them
    logic [TS_W-1:0]    ts_reg = '0;
    logic [TOTAL_W-1:0] total_reg = '0;
    logic [VPP_W-1:0]   vpp_reg = MAX_VPP;
    logic [VPP_W-1:0]   voxels_in_pkt = '0;
    logic [PKT_W-1:0]   pkt_number = '0;

    voxel_t       pending_voxels[$];
    stream_byte_t stream_bytes_due[$];
    voxel_t       offer;
    stream_byte_t due;

    logic voxel_taken = 1'b0;
    logic byte_taken = 1'b0;
    logic burst_mode = 1'b0;
    logic choke_req = 1'b0;
    int   choke_left = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   voxels_queued = 0;
    int   voxels_accepted = 0;
    int   bytes_checked = 0;
    int   packets_closed = 0;
    int   reg_writes = 0;
    int   fail_count = 0;
    int   cycle_count = 0;

    voxel_packet_framer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .frame_end  (frame_end),
        .empty      (empty),
        .pop        (pop),
        .data_byte  (data_byte),
        .packet_end (packet_end),
        .run_last   (run_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic append_byte(input logic [COLOR_W-1:0] data, input logic pkt_end,
                               input logic last);
        stream_byte_t sb;
        sb.data    = data;
        sb.pkt_end = pkt_end;
        sb.last    = last;
        stream_bytes_due.insert(stream_bytes_due.size(), sb);
    endtask

    task automatic emit_le(input logic [63:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            append_byte(value[8*i +: 8], 1'b0, 1'b0);
        end
    endtask

    // header (when a packet opens), then the voxel's 10 bytes
    task automatic frame_voxel(input voxel_t v);
        logic [VPP_W-1:0] limit;
        logic             closes;
        limit = vpp_reg;
        if (limit < MIN_VPP)
            limit = MIN_VPP;
        if (limit > MAX_VPP)
            limit = MAX_VPP;
        if (voxels_in_pkt == '0)
        begin
            emit_le(ts_reg, 8);
            emit_le(64'(pkt_number), 4);
            emit_le(64'(total_reg), 4);
        end
        emit_le(64'(v.x), 2);
        emit_le(64'(v.y), 2);
        emit_le(64'(v.z), 2);
        emit_le(64'(v.r), 1);
        emit_le(64'(v.g), 1);
        emit_le(64'(v.b), 1);
        voxels_in_pkt = voxels_in_pkt + VPP_W'(1);
        closes = v.last || (voxels_in_pkt >= limit);
        append_byte(COLOR_W'(0), closes, 1'b1);
        if (closes)
            packets_closed++;
        if (v.last)
        begin
            voxels_in_pkt = '0;
            pkt_number    = '0;
        end
        else if (closes)
        begin
            voxels_in_pkt = '0;
            pkt_number    = pkt_number + PKT_W'(1);
        end
    endtask

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic voxel_t make_voxel(
        input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
        input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
        input logic last);
        voxel_t v;
        v.x    = x;
        v.y    = y;
        v.z    = z;
        v.r    = r;
        v.g    = g;
        v.b    = b;
        v.last = last;
        return v;
    endfunction

    // upper bits are junk on purpose, only the low 13 count
    function automatic logic [CFG_DATA_W-1:0] pick_packet_size();
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom} & ~CFG_DATA_W'(13'h1FFF);
        case ($urandom_range(0, 9))
            0: return junk;
            1: return junk | CFG_DATA_W'(MIN_VPP);
            2: return junk | CFG_DATA_W'(13'h1FFF);
            3: return CFG_DATA_W'(MAX_VPP);
            default: return junk | CFG_DATA_W'($urandom_range(2, 6));
        endcase
    endfunction

    // sender: offers pending voxels, holds each until taken
    always @(negedge clk)
    begin
        if (rst_n && !(push && !voxel_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (pending_voxels.size() > 0)
            begin
                offer = pending_voxels.pop_front();
                coord_x   <= offer.x;
                coord_y   <= offer.y;
                coord_z   <= offer.z;
                red       <= offer.r;
                green     <= offer.g;
                blue      <= offer.b;
                frame_end <= offer.last;
                push      <= 1'b1;
                send_gap  = idle_len();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // receiver: random gaps plus one long choke on request
    always @(negedge clk)
    begin
        if (choke_req)
        begin
            choke_left = CHOKE_CYCLES;
            choke_req  = 1'b0;
        end
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (choke_left > 0)
        begin
            choke_left--;
            pop <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (byte_taken)
                recv_gap = idle_len();
        end
    end

    // monitor: check popped bytes first, then record accepted voxels
    always @(posedge clk)
    begin
        byte_taken = rst_n && pop && !empty;
        if (byte_taken)
        begin
            bytes_checked++;
            if (stream_bytes_due.size() == 0)
            begin
                $error("data_byte 0x%02h popped with nothing expected", data_byte);
                fail_count++;
            end
            else
            begin
                due = stream_bytes_due.pop_front();
                if (data_byte !== due.data)
                begin
                    $error("data_byte: expected 0x%02h, got 0x%02h", due.data, data_byte);
                    fail_count++;
                end
                if (packet_end !== due.pkt_end)
                begin
                    $error("packet_end: expected %0b, got %0b", due.pkt_end, packet_end);
                    fail_count++;
                end
                if (run_last !== due.last)
                begin
                    $error("run_last: expected %0b, got %0b", due.last, run_last);
                    fail_count++;
                end
            end
        end
        voxel_taken = rst_n && push && !full;
        if (voxel_taken)
        begin
            frame_voxel(offer);
            voxels_accepted++;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_TIMESTAMP:   ts_reg = value;
            CFG_VOXEL_TOTAL: total_reg = value[TOTAL_W-1:0];
            CFG_VPP:         vpp_reg = value[VPP_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        reg_writes++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (voxels_queued != voxels_accepted || stream_bytes_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // caller is aligned to a rising edge
    task automatic queue_voxel(input voxel_t v);
        pending_voxels.insert(pending_voxels.size(), v);
        voxels_queued++;
    endtask

    task automatic queue_frame(input int count, input logic closed);
        @(posedge clk);
        for (int k = 0; k < count; k++)
            queue_voxel(make_voxel(pick_coord(), pick_coord(), pick_coord(), pick_color(),
                                   pick_color(), pick_color(), closed && (k == count - 1)));
    endtask

    initial
    begin
        int   round;
        int   frames;
        int   len;
        int   random_voxels;
        logic closed;

        round = 0;
        random_voxels = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset registers, field extremes
        @(posedge clk);
        queue_voxel(make_voxel('0, '0, '0, '0, '0, '0, 1'b0));
        queue_voxel(make_voxel('1, '1, '1, '1, '1, '1, 1'b0));
        queue_voxel(make_voxel(16'h1234, 16'hABCD, 16'h8001, 8'h12, 8'h80, 8'h7F, 1'b1));
        wait_idle();

        // size 0 acts as 1; unmapped index must not land anywhere
        write_reg(CFG_TIMESTAMP, '1);
        write_reg(CFG_VOXEL_TOTAL, 64'hA5A5_A5A5_FFFF_FFFF);
        write_reg(CFG_VPP, 64'hFFFF_FFFF_FFFF_E000);
        write_reg(CFG_UNMAPPED, 64'h3);
        @(posedge clk);
        queue_voxel(make_voxel(16'hAAAA, 16'h5555, 16'hAAAA, 8'hAA, 8'h55, 8'hAA, 1'b0));
        queue_voxel(make_voxel(16'h5555, 16'hAAAA, 16'h5555, 8'h55, 8'hAA, 8'h55, 1'b0));
        queue_voxel(make_voxel(16'h0001, 16'h8000, 16'h7FFF, 8'h01, 8'hFE, 8'h80, 1'b1));
        wait_idle();

        // lower the size below the open packet's count
        write_reg(CFG_TIMESTAMP, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_VOXEL_TOTAL, 64'd12);
        write_reg(CFG_VPP, 64'd3);
        queue_frame(2, 1'b0);
        wait_idle();
        write_reg(CFG_VPP, CFG_DATA_W'(MIN_VPP));
        queue_frame(3, 1'b1);
        wait_idle();

        // oversized, then the maximum
        write_reg(CFG_VPP, 64'h1FFF);
        queue_frame(3, 1'b1);
        wait_idle();
        write_reg(CFG_VPP, CFG_DATA_W'(MAX_VPP));
        queue_frame(2, 1'b1);

        while (random_voxels < RANDOM_VOXELS)
        begin
            wait_idle();
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_TIMESTAMP, {$urandom, $urandom});
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_VOXEL_TOTAL, {$urandom, $urandom});
            write_reg(CFG_VPP, pick_packet_size());
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_UNMAPPED, {$urandom, $urandom});
            @(posedge clk);
            burst_mode = (round % 6 == 5);
            if (round == 3)
                choke_req = 1'b1;
            frames = (round == 3) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                len = (round == 3) ? 14 : $urandom_range(1, 10);
                closed = ($urandom_range(0, 4) != 0);
                queue_frame(len, closed);
                random_voxels += len;
            end
            round++;
        end

        wait_idle();
        repeat (50) @(negedge clk);
        $display("Framed %0d voxels into %0d packets; %0d bytes checked after %0d register writes.",
                 voxels_accepted, packets_closed, bytes_checked, reg_writes);
        $display("Packet sizes zero, one, small, maximum and oversized ran, with a long output stall.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/vpf_pkg.sv
rtl/vpf_front.sv
rtl/vpf_cmd_fifo.sv
rtl/vpf_back.sv
rtl/voxel_packet_framer_unit.sv
test/voxel_packet_framer_unit_tb.sv
